// ===== sv/hpp_pkg.sv =====
// ----------------------------------------------------------------------------
// hpp_pkg
// Shared types and constants of the hi-res pixel packer: channel payloads,
// register indexes, palette code layout and the palette color classifier.
// ----------------------------------------------------------------------------
package hpp_pkg;

    localparam int ROW_W      = 8;
    localparam int ADDR_W     = 13;
    localparam int ACC_W      = 14;
    localparam int VOTE_W     = 11;
    localparam int PIX_CNT_W  = 4;
    localparam int CODE_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Pixels per group in each mode.
    localparam logic [PIX_CNT_W-1:0] COLOR_GROUP = 4'd7;
    localparam logic [PIX_CNT_W-1:0] MONO_GROUP  = 4'd14;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_HIGH_BIT = 2'd2;

    // Input item kinds.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    // Palette code: bits 1..0 pixel code, bit 2 minus vote, bit 3 plus vote.
    localparam logic [CODE_W-1:0] CODE_BLACK  = 4'h0;
    localparam logic [CODE_W-1:0] CODE_WHITE  = 4'h3;
    localparam logic [CODE_W-1:0] CODE_BLUE   = 4'h9;
    localparam logic [CODE_W-1:0] CODE_PURPLE = 4'h5;
    localparam logic [CODE_W-1:0] CODE_ORANGE = 4'hA;
    localparam logic [CODE_W-1:0] CODE_GREEN  = 4'h6;
    localparam int FLAG_MINUS_BIT = 2;
    localparam int FLAG_PLUS_BIT  = 3;

    localparam logic signed [VOTE_W-1:0] VOTE_PLUS  = 11'sd128;
    localparam logic signed [VOTE_W-1:0] VOTE_MINUS = -11'sd64;

    typedef struct packed {
        logic       action;
        logic [7:0] pixel_index;
        logic [7:0] palette_slot;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_px_item;

    typedef struct packed {
        logic [ADDR_W-1:0] hgr_address;
        logic [7:0]        first_byte;
        logic [7:0]        second_byte;
        logic              frame_end;
    } t_grp_item;

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] code;
    } t_class;

    // Maps an RGB triple onto a palette code; hit is low for unknown colors.
    function automatic t_class classify(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        t_class res;
        res.hit  = 1'b1;
        res.code = CODE_BLACK;
        if (r == 8'h00 && g == 8'h00 && b == 8'h00) begin
            res.code = CODE_BLACK;
        end else if (r == 8'hff && g == 8'hff && b == 8'hff) begin
            res.code = CODE_WHITE;
        end else if (r == 8'h1b && g == 8'h9a && b == 8'hfe) begin
            res.code = CODE_BLUE;
        end else if (r == 8'he4 && g == 8'h34 && b == 8'hfe) begin
            res.code = CODE_PURPLE;
        end else if (r == 8'hcd && g == 8'h5b && b == 8'h01) begin
            res.code = CODE_ORANGE;
        end else if (r == 8'h1b && g == 8'hcb && b == 8'h01) begin
            res.code = CODE_GREEN;
        end else begin
            res.hit = 1'b0;
        end
        return res;
    endfunction

endpackage

// ===== sv/hpp_stream_if.sv =====
// ----------------------------------------------------------------------------
// hpp_stream_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface hpp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/hpp_ram.sv =====
// ----------------------------------------------------------------------------
// hpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hpp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/hires_pixel_packer.sv =====
// ----------------------------------------------------------------------------
// hires_pixel_packer
// Packs palette-indexed pixels into interleaved hi-res byte pairs.
// ----------------------------------------------------------------------------
// Input channel i_px takes two kinds of transaction. A load classifies an
// RGB triple into a palette code and writes it to palette_slot at once; an
// unknown color leaves the slot alone. A pixel looks up its palette code and
// is packed into the current group. A completed group (7 color pixels or 14
// mono pixels) leaves on o_grp as a byte address, two bytes and a frame end.
// The configuration port must be written only while idle; the block does not enforce it.
//
// Throughput is one transaction per cycle while the result register is empty or
// o_grp is ready. At acceptance a pixel is registered in the packing stage together
// with its palette read; from there it is packed into the group, and a completed
// group is registered in the result register for o_grp. Loads produce no output.
//
// Reset clears all counters and marks every palette entry black through one
// valid bit per entry, so no clearing pass is needed. When o_grp stalls, the
// result register holds and the packing stage keeps any pixel it has; i_px
// takes loads while the packing stage is empty; ready drops once it holds a pixel.
// ----------------------------------------------------------------------------
module hires_pixel_packer #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int GROUPS_PER_ROW  = 20,
    parameter int MAX_ROWS        = 192
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    hpp_stream_if.sink                     i_px,
    hpp_stream_if.source                   o_grp,
    input  logic                           i_cfg_we,
    input  logic [hpp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hpp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int GRP_W  = (GROUPS_PER_ROW > 1) ? $clog2(GROUPS_PER_ROW) : 1;
    localparam int ROW_W  = hpp_pkg::ROW_W;
    localparam int ACC_W  = hpp_pkg::ACC_W;
    localparam int VOTE_W = hpp_pkg::VOTE_W;
    localparam int PC_W   = hpp_pkg::PIX_CNT_W;
    localparam int ADDR_W = hpp_pkg::ADDR_W;

    // Configuration.
    logic             r_cfg_colour;
    logic [ROW_W-1:0] r_cfg_rows;
    logic             r_cfg_dhb;

    // Palette: valid bits, code RAM and a copy of the pixel code bits of slots 0..7.
    logic [PALETTE_ENTRIES-1:0] r_pal_valid;
    logic [1:0]                 r_shadow [8];

    // Packing stage input register.
    logic                      r_s1_valid;
    logic [1:0]                r_s1_bits;
    logic                      r_s1_vote_ok;
    logic [hpp_pkg::CODE_W-1:0] w_ram_rdata;

    // Group state.
    logic [ACC_W-1:0]         r_acc;
    logic signed [VOTE_W-1:0] r_low_vote;
    logic signed [VOTE_W-1:0] r_high_vote;
    logic [PC_W-1:0]          r_pig;
    logic [GRP_W-1:0]         r_grp;
    logic [ROW_W-1:0]         r_row;

    // Result register.
    logic               r_out_valid;
    hpp_pkg::t_grp_item r_out;

    logic [PAL_AW-1:0]      w_mod_tab [256];
    logic [PAL_AW-1:0]      w_slot;
    logic [PAL_AW-1:0]      w_pidx;
    hpp_pkg::t_class        w_class;
    logic                   w_accept;
    logic                   w_load;
    logic                   w_pixel;
    logic                   w_pal_we;
    logic                   w_s1_go;

    logic [hpp_pkg::CODE_W-1:0] w_code;
    logic signed [VOTE_W-1:0]   w_vote;
    logic [ACC_W-1:0]           n_acc;
    logic signed [VOTE_W-1:0]   n_low_vote;
    logic signed [VOTE_W-1:0]   n_high_vote;
    logic [PC_W-1:0]            n_pig;
    logic                       w_done;
    logic                       w_hb0;
    logic                       w_hb1;
    logic [ROW_W-1:0]           w_rows_eff;
    logic                       w_row_end;
    logic                       w_frame_end;
    logic [GRP_W-1:0]           n_grp;
    logic [ROW_W-1:0]           n_row;
    logic [ADDR_W-1:0]          w_addr;

    // Reduction of an 8-bit index onto the palette size, resolved at elaboration.
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign w_mod_tab[g] = PAL_AW'(g % PALETTE_ENTRIES);
    end

    assign w_slot   = w_mod_tab[i_px.data.palette_slot];
    assign w_pidx   = w_mod_tab[i_px.data.pixel_index];
    assign w_class  = hpp_pkg::classify(i_px.data.red, i_px.data.green, i_px.data.blue);
    assign w_accept = i_px.valid && i_px.ready;
    assign w_load   = w_accept && (i_px.data.action == hpp_pkg::ACT_LOAD);
    assign w_pixel  = w_accept && (i_px.data.action == hpp_pkg::ACT_PIXEL);
    assign w_pal_we = w_load && w_class.hit;

    assign w_s1_go    = r_s1_valid && (!r_out_valid || o_grp.ready);
    assign i_px.ready = !r_s1_valid || w_s1_go;

    hpp_ram #(
        .WIDTH (hpp_pkg::CODE_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_waddr (w_slot),
        .i_wdata (w_class.code),
        .i_re    (w_pixel),
        .i_raddr (w_pidx),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_colour <= 1'b1;
            r_cfg_rows   <= ROW_W'(192);
            r_cfg_dhb    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hpp_pkg::CFG_COLOUR_MODE:      r_cfg_colour <= i_cfg_data[0];
                hpp_pkg::CFG_ROW_COUNT:        r_cfg_rows   <= i_cfg_data[ROW_W-1:0];
                hpp_pkg::CFG_DEFAULT_HIGH_BIT: r_cfg_dhb    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_valid <= '0;
            for (int k = 0; k < 8; k++) begin
                r_shadow[k] <= 2'b00;
            end
        end else if (w_pal_we) begin
            r_pal_valid[w_slot] <= 1'b1;
            if ((PAL_AW+1)'(w_slot) < (PAL_AW+1)'(8)) begin
                r_shadow[w_slot[2:0]] <= w_class.code[1:0];
            end
        end
    end

    // The RAM read and the valid bit are sampled at the same edge as the pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_pixel) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_go) begin
            r_s1_valid <= 1'b0;
        end
        if (w_pixel) begin
            r_s1_bits    <= r_shadow[i_px.data.pixel_index[2:0]];
            r_s1_vote_ok <= r_pal_valid[w_pidx];
        end
    end

    // Packing of one pixel into the group.
    always_comb begin
        w_code      = r_s1_vote_ok ? w_ram_rdata : hpp_pkg::CODE_BLACK;
        w_vote      = '0;
        n_acc       = r_acc;
        n_low_vote  = r_low_vote;
        n_high_vote = r_high_vote;
        if (w_code[hpp_pkg::FLAG_PLUS_BIT]) begin
            w_vote = w_vote + hpp_pkg::VOTE_PLUS;
        end
        if (w_code[hpp_pkg::FLAG_MINUS_BIT]) begin
            w_vote = w_vote + hpp_pkg::VOTE_MINUS;
        end
        if (r_cfg_colour) begin
            for (int k = 0; k < 7; k++) begin
                if (r_pig == PC_W'(k)) begin
                    n_acc[2*k +: 2] = r_acc[2*k +: 2] | r_s1_bits;
                end
            end
            if (r_pig < PC_W'(4)) begin
                n_low_vote = r_low_vote + w_vote;
            end else begin
                n_high_vote = r_high_vote + w_vote;
            end
            w_done = (r_pig + PC_W'(1)) >= hpp_pkg::COLOR_GROUP;
        end else begin
            for (int k = 0; k < ACC_W; k++) begin
                if (r_pig == PC_W'(k)) begin
                    n_acc[k] = r_acc[k] | r_s1_bits[0];
                end
            end
            w_done = (r_pig + PC_W'(1)) >= hpp_pkg::MONO_GROUP;
        end
        n_pig = r_pig + PC_W'(1);

        // A zero vote takes the configured default high bit.
        w_hb0 = (n_low_vote == '0)  ? r_cfg_dhb : !n_low_vote[VOTE_W-1];
        w_hb1 = (n_high_vote == '0) ? r_cfg_dhb : !n_high_vote[VOTE_W-1];
        if (!r_cfg_colour) begin
            w_hb0 = 1'b0;
            w_hb1 = 1'b0;
        end
    end

    // Group and row counters, byte address.
    always_comb begin
        if (r_cfg_rows == '0) begin
            w_rows_eff = ROW_W'(1);
        end else if (r_cfg_rows > ROW_W'(MAX_ROWS)) begin
            w_rows_eff = ROW_W'(MAX_ROWS);
        end else begin
            w_rows_eff = r_cfg_rows;
        end

        w_row_end   = ({1'b0, r_grp} + (GRP_W+1)'(1)) >= (GRP_W+1)'(GROUPS_PER_ROW);
        w_frame_end = 1'b0;
        n_grp       = r_grp + GRP_W'(1);
        n_row       = r_row;
        if (w_row_end) begin
            n_grp = '0;
            if (({1'b0, r_row} + (ROW_W+1)'(1)) >= {1'b0, w_rows_eff}) begin
                n_row       = '0;
                w_frame_end = 1'b1;
            end else begin
                n_row = r_row + ROW_W'(1);
            end
        end

        // Interleaved layout: (r%8)*1024 + ((r/8)%8)*128 + (r/64)*40 + 2*group.
        w_addr = ADDR_W'({r_row[2:0], 10'b0})
               + ADDR_W'({r_row[5:3], 7'b0})
               + ADDR_W'({r_row[7:6], 5'b0})
               + ADDR_W'({r_row[7:6], 3'b0})
               + ADDR_W'({r_grp, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_low_vote  <= '0;
            r_high_vote <= '0;
            r_pig       <= '0;
            r_grp       <= '0;
            r_row       <= '0;
        end else if (w_s1_go) begin
            if (w_done) begin
                r_acc       <= '0;
                r_low_vote  <= '0;
                r_high_vote <= '0;
                r_pig       <= '0;
                r_grp       <= n_grp;
                r_row       <= n_row;
            end else begin
                r_acc       <= n_acc;
                r_low_vote  <= n_low_vote;
                r_high_vote <= n_high_vote;
                r_pig       <= n_pig;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go && w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_grp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_s1_go && w_done) begin
            r_out.hgr_address <= w_addr;
            r_out.first_byte  <= {w_hb0, n_acc[6:0]};
            r_out.second_byte <= {w_hb1, n_acc[13:7]};
            r_out.frame_end   <= w_frame_end;
        end
    end

    assign o_grp.valid = r_out_valid;
    assign o_grp.data  = r_out;

    // A stalled packing stage keeps its pixel.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_go |=> r_s1_valid && $stable(r_s1_bits))
        else $error("packing stage lost a stalled pixel");

    // Input is refused only when both the packing stage and the result are full.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_px.ready |-> r_s1_valid && r_out_valid)
        else $error("input refused with room in the pipeline");

    // A completed group starts the next one empty.
    a_group_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_go && w_done |=> r_pig == '0 && r_acc == '0 && r_out_valid)
        else $error("group state not cleared after a result");

    // A frame end sends the counters back to the first group of row zero.
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_go && w_done && w_frame_end |=> r_row == '0 && r_grp == '0)
        else $error("counters did not wrap at frame end");

endmodule

// ===== sim/tb_hires_pixel_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hires_pixel_packer
// Self-checking bench for the hi-res pixel packer. Palette loads and pixels
// are streamed in with random gaps while the group output stalls at random.
// A scoreboard rebuilds each byte pair and address from the accepted
// transactions and compares every group field by field.
// ----------------------------------------------------------------------------

package hpp_tb_pkg;
    import hpp_pkg::*;

    localparam int GROUPS_PER_ROW = 20;
    localparam int MAX_ROWS       = 192;

    localparam logic [23:0] RGB_BLACK  = 24'h000000;
    localparam logic [23:0] RGB_WHITE  = 24'hffffff;
    localparam logic [23:0] RGB_BLUE   = 24'h1b9afe;
    localparam logic [23:0] RGB_PURPLE = 24'he434fe;
    localparam logic [23:0] RGB_ORANGE = 24'hcd5b01;
    localparam logic [23:0] RGB_GREEN  = 24'h1bcb01;

    function automatic logic [23:0] known_rgb(input int k);
        case (k)
            0:       return RGB_BLACK;
            1:       return RGB_WHITE;
            2:       return RGB_BLUE;
            3:       return RGB_PURPLE;
            4:       return RGB_ORANGE;
            default: return RGB_GREEN;
        endcase
    endfunction

    class group_predictor;
        logic [CODE_W-1:0] codes [256];
        logic [ACC_W-1:0]  acc_bits;
        int                low_vote;
        int                high_vote;
        int                pix_count;
        int                group_in_row;
        int                row_number;
        logic              colour_mode;
        logic [7:0]        row_count;
        logic              default_hb;
        t_grp_item         expected_groups [$];
        int                errors;

        function new();
            foreach (codes[i]) codes[i] = CODE_BLACK;
            acc_bits     = '0;
            low_vote     = 0;
            high_vote    = 0;
            pix_count    = 0;
            group_in_row = 0;
            row_number   = 0;
            colour_mode  = 1'b1;
            row_count    = 8'd192;
            default_hb   = 1'b1;
            errors       = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_COLOUR_MODE:      colour_mode = val[0];
                CFG_ROW_COUNT:        row_count   = val;
                CFG_DEFAULT_HIGH_BIT: default_hb  = val[0];
                default: ;
            endcase
        endfunction

        function logic high_bit(input int vote);
            if (vote > 0) return 1'b1;
            if (vote < 0) return 1'b0;
            return default_hb;
        endfunction

        function int pending();
            return expected_groups.size();
        endfunction

        // Folds one accepted transaction into the model and queues the group
        // it completes, if any.
        function void take_item(input t_px_item it);
            logic [CODE_W-1:0] bit_code;
            logic [CODE_W-1:0] vote_code;
            int                p;
            int                vote;
            int                group_size;
            int                r;
            int                eff_rows;
            t_grp_item         g;

            if (it.action == ACT_LOAD) begin
                // An unknown color leaves the slot as it was.
                case ({it.red, it.green, it.blue})
                    RGB_BLACK:  codes[it.palette_slot] = CODE_BLACK;
                    RGB_WHITE:  codes[it.palette_slot] = CODE_WHITE;
                    RGB_BLUE:   codes[it.palette_slot] = CODE_BLUE;
                    RGB_PURPLE: codes[it.palette_slot] = CODE_PURPLE;
                    RGB_ORANGE: codes[it.palette_slot] = CODE_ORANGE;
                    RGB_GREEN:  codes[it.palette_slot] = CODE_GREEN;
                    default: ;
                endcase
                return;
            end

            // Pixel bits come from the first eight slots, the vote from the full index.
            bit_code  = codes[it.pixel_index[2:0]];
            vote_code = codes[it.pixel_index];
            p         = pix_count;
            if (colour_mode) begin
                if (p < 7) acc_bits = acc_bits | ACC_W'(int'(bit_code[1:0]) << (2 * p));
                vote = 0;
                if (vote_code[FLAG_PLUS_BIT])  vote += int'(VOTE_PLUS);
                if (vote_code[FLAG_MINUS_BIT]) vote += int'(VOTE_MINUS);
                if (p < 4) low_vote += vote;
                else high_vote += vote;
                group_size = 7;
            end else begin
                if (p < 14) acc_bits = acc_bits | ACC_W'(int'(bit_code[0]) << p);
                group_size = 14;
            end
            pix_count = p + 1;
            if (pix_count < group_size) return;

            g.first_byte  = {colour_mode ? high_bit(low_vote) : 1'b0, acc_bits[6:0]};
            g.second_byte = {colour_mode ? high_bit(high_vote) : 1'b0, acc_bits[13:7]};
            r = row_number;
            g.hgr_address = ADDR_W'((r % 8) * 1024 + ((r / 8) % 8) * 128 + (r / 64) * 40
                                    + 2 * group_in_row);
            eff_rows = (row_count == 8'd0) ? 1
                     : ((int'(row_count) > MAX_ROWS) ? MAX_ROWS : int'(row_count));
            g.frame_end = 1'b0;

            acc_bits  = '0;
            low_vote  = 0;
            high_vote = 0;
            pix_count = 0;

            if (group_in_row + 1 >= GROUPS_PER_ROW) begin
                group_in_row = 0;
                // A row number already past the count also ends the frame.
                if (row_number + 1 >= eff_rows) begin
                    row_number  = 0;
                    g.frame_end = 1'b1;
                end else begin
                    row_number = row_number + 1;
                end
            end else begin
                group_in_row = group_in_row + 1;
            end
            expected_groups.push_back(g);
        endfunction

        function void report(input string field, input int want, input int got);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_group(input t_grp_item got);
            t_grp_item want;
            if (expected_groups.size() == 0) begin
                $display("%0t: unexpected group, expected none, actual addr %0h bytes %0h %0h",
                         $time, got.hgr_address, got.first_byte, got.second_byte);
                errors++;
                return;
            end
            want = expected_groups.pop_front();
            if (want.hgr_address != got.hgr_address)
                report("hgr_address", int'(want.hgr_address), int'(got.hgr_address));
            if (want.first_byte != got.first_byte)
                report("first_byte", int'(want.first_byte), int'(got.first_byte));
            if (want.second_byte != got.second_byte)
                report("second_byte", int'(want.second_byte), int'(got.second_byte));
            if (want.frame_end != got.frame_end)
                report("frame_end", int'(want.frame_end), int'(got.frame_end));
        endfunction
    endclass

endpackage

module tb_hires_pixel_packer;
    import hpp_pkg::*;
    import hpp_tb_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int RUN_LIMIT_NS  = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int src_idle_pct   = 36;
    int sink_stall_pct = 36;

    group_predictor sb = new();

    hpp_stream_if #(.T(t_px_item))  px_if ();
    hpp_stream_if #(.T(t_grp_item)) grp_if ();

    hires_pixel_packer #(
        .PALETTE_ENTRIES (256),
        .GROUPS_PER_ROW  (GROUPS_PER_ROW),
        .MAX_ROWS        (MAX_ROWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_px        (px_if),
        .o_grp       (grp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    initial begin
        grp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            grp_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (px_if.valid && px_if.ready) sb.take_item(px_if.data);
            if (grp_if.valid && grp_if.ready) sb.check_group(grp_if.data);
        end
    end

    function automatic t_px_item load_item(input logic [7:0] slot, input logic [23:0] rgb);
        t_px_item it;
        it.action       = ACT_LOAD;
        it.pixel_index  = 8'($urandom_range(0, 255));
        it.palette_slot = slot;
        {it.red, it.green, it.blue} = rgb;
        return it;
    endfunction

    function automatic t_px_item pixel_item(input logic [7:0] idx);
        t_px_item it;
        it.action       = ACT_PIXEL;
        it.pixel_index  = idx;
        it.palette_slot = 8'($urandom_range(0, 255));
        it.red          = 8'($urandom_range(0, 255));
        it.green        = 8'($urandom_range(0, 255));
        it.blue         = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic t_px_item rand_item();
        logic [7:0]  slot;
        logic [23:0] rgb;
        int          pick;
        if ($urandom_range(0, 99) < 15) begin
            slot = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                               : 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 7);
            if (pick < 6) begin
                rgb = known_rgb(pick);
            end else if (pick == 6) begin
                // Near miss: one bit away from a known color.
                rgb = known_rgb($urandom_range(0, 5)) ^ (24'h1 << $urandom_range(0, 23));
            end else begin
                rgb = 24'($urandom());
            end
            return load_item(slot, rgb);
        end
        return pixel_item(($urandom_range(0, 9) < 4) ? 8'($urandom_range(0, 7))
                                                     : 8'($urandom_range(0, 255)));
    endfunction

    task automatic idle_gap();
        while ($urandom_range(0, 99) < src_idle_pct) begin
            px_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_item(input t_px_item it);
        idle_gap();
        px_if.data  <= it;
        px_if.valid <= 1'b1;
        do @(posedge i_clk); while (!px_if.ready);
    endtask

    task automatic drain();
        px_if.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        // Loads and partial groups give no result, so let the pipeline settle.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic configure(input logic mode, input logic [7:0] rows, input logic dhb);
        write_one(CFG_COLOUR_MODE, {7'b0, mode});
        write_one(CFG_ROW_COUNT, rows);
        write_one(CFG_DEFAULT_HIGH_BIT, {7'b0, dhb});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int         n;
        logic [7:0] rows;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_COLOUR_MODE;
        i_cfg_data  <= '0;
        px_if.valid <= 1'b0;
        px_if.data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every palette color, an unknown color over a loaded slot, the top slot.
        for (int k = 0; k < 6; k++) send_item(load_item(8'(k), known_rgb(k)));
        send_item(load_item(8'd7, RGB_WHITE));
        send_item(load_item(8'd7, 24'h1b9aff));
        send_item(load_item(8'd255, RGB_PURPLE));
        // First group: positive low vote, high vote that cancels to zero.
        send_item(pixel_item(8'd0));
        send_item(pixel_item(8'd1));
        send_item(pixel_item(8'd2));
        send_item(pixel_item(8'd3));
        send_item(pixel_item(8'd4));
        send_item(pixel_item(8'd5));
        send_item(pixel_item(8'd255));
        // Second group: zero low vote, negative high vote.
        send_item(pixel_item(8'd7));
        send_item(pixel_item(8'd6));
        send_item(pixel_item(8'd0));
        send_item(pixel_item(8'd7));
        send_item(pixel_item(8'd3));
        send_item(pixel_item(8'd6));
        send_item(pixel_item(8'd248));
        drain();

        // Phase lengths are ragged so that groups straddle mode changes and
        // row counts drop below the current row.
        for (int ph = 0; ph < 14; ph++) begin
            src_idle_pct   = 36;
            sink_stall_pct = 36;
            case (ph)
                0: begin configure(1'b1, 8'd192, 1'b1); n = 300; end
                1: begin configure(1'b0, 8'd1, 1'b0);   n = 250; end
                2: begin configure(1'b1, 8'd0, 1'b0);   n = 200; end
                3: begin
                    configure(1'b1, 8'd3, 1'b1);
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    n = 250;
                end
                4: begin configure(1'b0, 8'd255, 1'b1); n = 150; end
                5: begin configure(1'b1, 8'd200, 1'b0); n = 150; end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       rows = 8'd0;
                        1:       rows = 8'($urandom_range(1, 4));
                        2:       rows = 8'(MAX_ROWS);
                        default: rows = 8'($urandom_range(MAX_ROWS + 1, 255));
                    endcase
                    configure(1'($urandom_range(0, 1)), rows, 1'($urandom_range(0, 1)));
                    n = 60;
                end
            endcase
            n = n + $urandom_range(0, 13);
            for (int i = 0; i < n; i++) send_item(rand_item());
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
